FILE: rtl/core/nief_pkg.sv
// Package for the nearest interval element finder.
// Holds register codes, reset values and the position configuration struct.
// No dependencies.
`default_nettype none

package nief_pkg;

  localparam int MaxElementsDef = 16;
  localparam int MaxNodesDef    = 1024;

  localparam int ONE_Q16 = 65536;

  // Configuration register indexes.
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_GRID_ORIGIN   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CELL_SIZE     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BOOST_FACTOR  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BOOST_OFFSET  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ELEMENT_COUNT = 3'd4;

  localparam int CfgDataW = 32;

  // Request types.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Register reset values.
  localparam logic signed [31:0] GRID_ORIGIN_RST   = 32'sd0;
  localparam logic [30:0]        CELL_SIZE_RST     = 31'(ONE_Q16);
  localparam logic [23:0]        BOOST_FACTOR_RST  = 24'(ONE_Q16);
  localparam logic signed [31:0] BOOST_OFFSET_RST  = 32'sd0;
  localparam logic [4:0]         ELEMENT_COUNT_RST = 5'd0;

  typedef struct packed {
    logic signed [31:0] grid_origin;
    logic [30:0]        cell_size;
    logic [23:0]        boost_factor;
    logic signed [31:0] boost_offset;
  } pos_cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/nief_pos_unit.sv
// Position arithmetic pipeline: node position and optional boost mapping.
// Four stages; returns twice the final Q16.16 position. Uses nief_pkg.
`default_nettype none

module nief_pos_unit
  import nief_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               go_i,
  input  wire logic [9:0]         node_i,
  input  wire pos_cfg_t           cfg_i,
  output logic                    done_o,
  output logic signed [32:0]      twice_o
);

  logic [3:0]         vld_q;
  logic [40:0]        prod1_q;
  logic signed [31:0] pos1_q;
  logic signed [31:0] pos1_d;
  logic signed [56:0] prod2_q;
  logic signed [31:0] pos2_q;
  logic               boost_q;
  logic signed [31:0] pos3_q;
  logic signed [31:0] pos3_d;
  logic signed [42:0] sum1;
  logic signed [40:0] scaled;
  logic signed [41:0] sum2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], go_i};
    end
  end

  // Stage 2: origin plus node offset, saturated to 32 bits.
  always_comb begin
    sum1 = $signed({{11{cfg_i.grid_origin[31]}}, cfg_i.grid_origin})
         + $signed({2'b00, prod1_q});
    if (sum1[42:31] == {12{sum1[42]}}) begin
      pos1_d = sum1[31:0];
    end else if (sum1[42]) begin
      pos1_d = {1'b1, 31'd0};
    end else begin
      pos1_d = {1'b0, {31{1'b1}}};
    end
  end

  // Stage 4: with boost on, floor shift of the product, offset added, saturated; else the position passes through.
  always_comb begin
    scaled = prod2_q[56:16];
    sum2   = $signed({scaled[40], scaled})
           + $signed({{10{cfg_i.boost_offset[31]}}, cfg_i.boost_offset});
    if (!boost_q) begin
      pos3_d = pos2_q;
    end else if (sum2[41:31] == {11{sum2[41]}}) begin
      pos3_d = sum2[31:0];
    end else if (sum2[41]) begin
      pos3_d = {1'b1, 31'd0};
    end else begin
      pos3_d = {1'b0, {31{1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    prod1_q <= node_i * cfg_i.cell_size;
    pos1_q  <= pos1_d;
    prod2_q <= $signed({1'b0, cfg_i.boost_factor}) * pos1_q;
    pos2_q  <= pos1_q;
    boost_q <= (cfg_i.boost_factor > 24'(ONE_Q16));
    pos3_q  <= pos3_d;
  end

  assign done_o  = vld_q[3];
  assign twice_o = {pos3_q, 1'b0};

endmodule

`default_nettype wire

FILE: rtl/core/nief_elem_mem.sv
// Element table: start and end positions in two synchronous memories.
// One write port and one registered read port each. Uses nief_pkg.
`default_nettype none

module nief_elem_mem
  import nief_pkg::*;
#(
  parameter int Depth = MaxElementsDef,
  parameter int AddrW = 4
) (
  input  wire logic                    clk_i,
  input  wire logic                    wr_en_i,
  input  wire logic [AddrW-1:0]        wr_addr_i,
  input  wire logic signed [31:0]      wr_start_i,
  input  wire logic signed [31:0]      wr_end_i,
  input  wire logic                    rd_en_i,
  input  wire logic [AddrW-1:0]        rd_addr_i,
  output logic signed [31:0]           rd_start_o,
  output logic signed [31:0]           rd_end_o
);

  logic signed [31:0] starts_mem [Depth];
  logic signed [31:0] ends_mem   [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      starts_mem[wr_addr_i] <= wr_start_i;
      ends_mem[wr_addr_i]   <= wr_end_i;
    end
    if (rd_en_i) begin
      rd_start_o <= starts_mem[rd_addr_i];
      rd_end_o   <= ends_mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/nearest_interval_element_finder_top.sv
// Top level of the nearest interval element finder.
// Holds configuration registers and the table walk; uses nief_pkg,
// nief_pos_unit and nief_elem_mem.
//
// Usage: an item is transferred at a rising edge with start high and busy low.
// A load item (req_type_i = 0) writes one table slot at that edge and returns
// no result; busy stays low, so another item may follow in the next cycle.
// A query item (req_type_i = 1) raises busy while the block computes the node
// position in a four-stage arithmetic pipeline and then reads the table one
// entry per cycle through the memory read port, comparing midpoints as it
// goes. With no elements or a node outside the grid, the result comes in the
// cycle after the transfer. The table read port, one entry a cycle, sets the
// walk length. The result is on nearest_element_o and matched_o, held until
// the next query is taken, and done_o marks it for exactly one cycle; the
// receiver cannot stall it. The user must write configuration through
// cfg_we_i, cfg_idx_i and cfg_wdata_i only while the block is idle; the
// block itself does not enforce this. Reset restores the register defaults
// and clears the control state; table entries hold no defined value until
// loaded.
`default_nettype none

module nearest_interval_element_finder_top
  import nief_pkg::*;
#(
  parameter int MAX_ELEMENTS = MaxElementsDef,
  parameter int MAX_NODES    = MaxNodesDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                req_type_i,
  input  wire logic [3:0]          element_slot_i,
  input  wire logic signed [31:0]  start_pos_i,
  input  wire logic signed [31:0]  end_pos_i,
  input  wire logic [9:0]          node_index_i,
  output logic                     done_o,
  output logic [3:0]               nearest_element_o,
  output logic                     matched_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int AddrW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_POS  = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;

  pos_cfg_t   cfg_q;
  logic [4:0] count_q;
  logic [4:0] count_lim;

  logic [1:0]         state_q;
  logic [4:0]         fetch_q;
  logic               rd_vld_q;
  logic [4:0]         rd_tag_q;
  logic signed [31:0] prev_end_q;
  logic               lprev_q;
  logic signed [32:0] twice_q;
  logic [3:0]         found_q;
  logic               hit_q;
  logic               done_q;

  logic               accept;
  logic               wr_en;
  logic               rd_en;
  logic               pos_go;
  logic               pos_done;
  logic signed [32:0] pos_twice;
  logic signed [31:0] rd_start;
  logic signed [31:0] rd_end;
  logic signed [32:0] mid_sum;
  logic               lcur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_origin  <= GRID_ORIGIN_RST;
      cfg_q.cell_size    <= CELL_SIZE_RST;
      cfg_q.boost_factor <= BOOST_FACTOR_RST;
      cfg_q.boost_offset <= BOOST_OFFSET_RST;
      count_q            <= ELEMENT_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRID_ORIGIN:   cfg_q.grid_origin  <= cfg_wdata_i;
        CFG_CELL_SIZE:     cfg_q.cell_size    <= cfg_wdata_i[30:0];
        CFG_BOOST_FACTOR:  cfg_q.boost_factor <= cfg_wdata_i[23:0];
        CFG_BOOST_OFFSET:  cfg_q.boost_offset <= cfg_wdata_i;
        CFG_ELEMENT_COUNT: count_q            <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  assign count_lim = (32'(count_q) > MAX_ELEMENTS) ? 5'(MAX_ELEMENTS) : count_q;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign wr_en  = accept && (req_type_i == REQ_LOAD) && (32'(element_slot_i) < MAX_ELEMENTS);
  assign pos_go = accept && (req_type_i == REQ_QUERY) && (32'(node_index_i) < MAX_NODES)
               && (count_lim != 5'd0);
  assign rd_en  = (state_q == ST_WALK) && (fetch_q < count_lim);

  // Boundary test for the element that just arrived: the doubled midpoint
  // with the previous element's end must not lie above twice the position.
  assign mid_sum = $signed({prev_end_q[31], prev_end_q}) + $signed({rd_start[31], rd_start});
  assign lcur    = (rd_tag_q == 5'd0) || (mid_sum <= twice_q);

  nief_pos_unit u_pos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (pos_go),
    .node_i  (node_index_i),
    .cfg_i   (cfg_q),
    .done_o  (pos_done),
    .twice_o (pos_twice)
  );

  nief_elem_mem #(
    .Depth (MAX_ELEMENTS),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (AddrW'(element_slot_i)),
    .wr_start_i (start_pos_i),
    .wr_end_i   (end_pos_i),
    .rd_en_i    (rd_en),
    .rd_addr_i  (AddrW'(fetch_q)),
    .rd_start_o (rd_start),
    .rd_end_o   (rd_end)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fetch_q  <= '0;
      rd_vld_q <= 1'b0;
      rd_tag_q <= '0;
      lprev_q  <= 1'b0;
      found_q  <= '0;
      hit_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q   <= 1'b0;
      rd_vld_q <= rd_en;
      rd_tag_q <= fetch_q;
      case (state_q)
        ST_IDLE: begin
          if (accept && (req_type_i == REQ_QUERY)) begin
            found_q <= '0;
            hit_q   <= 1'b0;
            if (pos_go) begin
              state_q <= ST_POS;
            end else begin
              done_q <= 1'b1;
            end
          end
        end
        ST_POS: begin
          if (pos_done) begin
            fetch_q <= '0;
            state_q <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (rd_en) begin
            fetch_q <= fetch_q + 5'd1;
          end
          if (rd_vld_q) begin
            lprev_q <= lcur;
            // Element before this one is covered when its left bound held
            // and this element's left bound does not.
            if ((rd_tag_q != 5'd0) && lprev_q && !lcur) begin
              found_q <= 4'(rd_tag_q - 5'd1);
              hit_q   <= 1'b1;
            end
            if (rd_tag_q == count_lim - 5'd1) begin
              if (lcur) begin
                found_q <= 4'(rd_tag_q);
                hit_q   <= 1'b1;
              end
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_POS && pos_done) begin
      twice_q <= pos_twice;
    end
    if (rd_vld_q) begin
      prev_end_q <= rd_end;
    end
  end

  assign done_o            = done_q;
  assign nearest_element_o = found_q;
  assign matched_o         = hit_q;

endmodule

`default_nettype wire
